>>> rtl/crmu_pkg.sv
// crmu_pkg: shared types and constants for the credit region merge block
// holds the item structs, the store entry layout and register indexes
// no dependencies
`timescale 1ns / 1ps

package crmu_pkg;

   localparam int PIX_BITS    = 12;
   localparam int PIX_COUNT   = 4096;
   localparam int SIZE_BITS   = 13;
   localparam int CREDIT_BITS = 24;
   localparam int WEIGHT_BITS = 16;
   localparam int CSR_BITS    = 16;
   localparam int CSR_IDX_BITS = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_WEIGHT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MULTIPLIER = 2'd2;

   // command codes
   localparam logic CMD_EDGE  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // 4*pi in Q32
   localparam logic [35:0] FOUR_PI_Q32 = 36'd53972150818;

   typedef struct packed {
      logic                   command;
      logic [PIX_BITS-1:0]    pixel_a;
      logic [PIX_BITS-1:0]    pixel_b;
      logic [WEIGHT_BITS-1:0] edge_weight;
   } crmu_req_type;

   typedef struct packed {
      logic                   merged;
      logic [PIX_BITS-1:0]    root_label;
      logic [SIZE_BITS-1:0]   region_size;
      logic [CREDIT_BITS-1:0] region_credit;
   } crmu_rsp_type;

   // one entry of the region store
   typedef struct packed {
      logic [PIX_BITS-1:0]    parent;
      logic [SIZE_BITS-1:0]   size;
      logic [CREDIT_BITS-1:0] credit;
      logic                   known;
   } crmu_ent_type;

   // request to and result from the credit unit
   typedef struct packed {
      logic                 start;
      logic [SIZE_BITS-1:0] size;
   } crmu_crd_req_type;

   typedef struct packed {
      logic                   done;
      logic [CREDIT_BITS-1:0] credit;
   } crmu_crd_res_type;

endpackage

>>> rtl/crmu_credit_unit.sv
// crmu_credit_unit: initial region credit ceil(sqrt(size*4pi) * multiplier/256)
// constant product in two halves, bit-serial square root, one scale multiply
// depends on crmu_pkg
`timescale 1ns / 1ps

module crmu_credit_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [crmu_pkg::CSR_BITS-1:0] mult,
   input  crmu_pkg::crmu_crd_req_type crd_req,
   output crmu_pkg::crmu_crd_res_type crd_res
);
   import crmu_pkg::*;

   localparam logic [2:0] U_IDLE  = 3'd0;
   localparam logic [2:0] U_MLO   = 3'd1;
   localparam logic [2:0] U_MHI   = 3'd2;
   localparam logic [2:0] U_SQRT  = 3'd3;
   localparam logic [2:0] U_SCALE = 3'd4;
   localparam logic [2:0] U_FIN   = 3'd5;

   localparam logic [17:0] C_LO = FOUR_PI_Q32[17:0];
   localparam logic [17:0] C_HI = FOUR_PI_Q32[35:18];
   localparam logic [41:0] ROUND_UP = 42'hFFFFFF;

   logic [2:0]           state_ff, state_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [CSR_BITS-1:0]  mult_ff, mult_in;
   logic [49:0]          acc_ff, acc_in;
   logic [26:0]          rem_ff, rem_in;
   logic [24:0]          root_ff, root_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [40:0]          prod_ff, prod_in;

   logic [30:0] pp;
   logic [28:0] rem_sh;
   logic [28:0] trial;
   logic [28:0] diff;
   logic [41:0] sum;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      size_ff <= size_in;
      mult_ff <= mult_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

   // partial product, one root bit per cycle, and the rounded-up sum
   always_comb begin
      pp      = 31'(size_ff) * 31'((state_ff == U_MLO) ? C_LO : C_HI);
      rem_sh  = {rem_ff, acc_ff[49:48]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = rem_sh - trial;
      sum     = {1'b0, prod_ff} + ROUND_UP;
   end

   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      mult_in  = mult_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (crd_req.start) begin
               size_in  = crd_req.size;
               mult_in  = mult;
               state_in = U_MLO;
            end
         end
         U_MLO: begin
            acc_in   = {19'd0, pp};
            state_in = U_MHI;
         end
         U_MHI: begin
            acc_in   = acc_ff + {1'b0, pp, 18'd0};
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = U_SQRT;
         end
         U_SQRT: begin
            acc_in = {acc_ff[47:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = diff[26:0];
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               rem_in  = rem_sh[26:0];
               root_in = {root_ff[23:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd24) begin
               state_in = U_SCALE;
            end
         end
         U_SCALE: begin
            prod_in  = 41'(root_ff) * 41'(mult_ff);
            state_in = U_FIN;
         end
         U_FIN: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   // rounded-up credit, always below the 24-bit limit
   assign crd_res.done   = (state_ff == U_FIN);
   assign crd_res.credit = {6'd0, sum[41:24]};

endmodule

>>> rtl/credit_region_merge_union_find.sv
// credit_region_merge_union_find: union-find region merging with lazy credit
// sequencer around one region store, plus the credit unit
// depends on crmu_pkg and crmu_credit_unit
//
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_data (command, pixels, weight)
// rsp     | out       | rsp_valid/rsp_ready  | rsp_data (merged, root, size, credit)
// csr     | in        | csr_we               | csr_index, csr_wdata
//
// one item at a time: the item is taken in S_IDLE, one store read per pixel on each
// root path, in the credit phase a credit check on root A and, if needed, root B, plus a run of the credit
// unit when that root's credit is not yet known, then S_DECIDE, on a merge S_LINK
// and S_GROW, then S_DONE; after reset a clearing pass over all 4096 entries fills
// the store and no item is taken; the next item is taken while a result still waits on rsp
`timescale 1ns / 1ps

module credit_region_merge_union_find (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  crmu_pkg::crmu_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output crmu_pkg::crmu_rsp_type            rsp_data,
   input  logic                              csr_we,
   input  logic [crmu_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [crmu_pkg::CSR_BITS-1:0]     csr_wdata
);
   import crmu_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_WALK_A = 4'd2;
   localparam logic [3:0] S_WALK_B = 4'd3;
   localparam logic [3:0] S_CRED_A = 4'd4;
   localparam logic [3:0] S_WAIT_A = 4'd5;
   localparam logic [3:0] S_CRED_B = 4'd6;
   localparam logic [3:0] S_WAIT_B = 4'd7;
   localparam logic [3:0] S_DECIDE = 4'd8;
   localparam logic [3:0] S_LINK   = 4'd9;
   localparam logic [3:0] S_GROW   = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   // region store
   crmu_ent_type mem [PIX_COUNT];
   crmu_ent_type rd_ent_ff;
   logic [PIX_BITS-1:0] rd_addr, wr_addr;
   crmu_ent_type wr_ent;
   logic wr_en;

   // control
   logic [3:0]            state_ff, state_in;
   logic                  phase_ff, phase_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_BITS-1:0]   clr_ff, clr_in;
   logic [WEIGHT_BITS-1:0] min_w_ff, max_w_ff;
   logic [CSR_BITS-1:0]   mult_ff;

   // item registers
   logic                   cmd_ff, cmd_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [PIX_BITS-1:0]    b_ff, b_in;
   logic [PIX_BITS-1:0]    cur_ff, cur_in;
   logic [PIX_BITS-1:0]    ra_ff, ra_in, rb_ff, rb_in;
   logic [SIZE_BITS-1:0]   sa_ff, sa_in, sb_ff, sb_in;
   logic [CREDIT_BITS-1:0] ca_ff, ca_in, cb_ff, cb_in;
   logic                   ka_ff, ka_in, kb_ff, kb_in;
   logic [PIX_BITS-1:0]    keep_ff, keep_in, lose_ff, lose_in;
   logic [CREDIT_BITS-1:0] gcred_ff, gcred_in;
   logic                   gknown_ff, gknown_in;
   crmu_rsp_type           pend_ff, pend_in;
   crmu_rsp_type           rsp_ff, rsp_in;

   // decision terms
   logic                   cand, both, need_b, merge;
   logic [CREDIT_BITS-1:0] pair;
   logic [PIX_BITS-1:0]    keep_sel, lose_sel;

   crmu_crd_req_type crd_req;
   crmu_crd_res_type crd_res;

   crmu_credit_unit u_credit (
      .clock   (clock),
      .reset   (reset),
      .mult    (mult_ff),
      .crd_req (crd_req),
      .crd_res (crd_res)
   );

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_ent;
      end
      rd_ent_ff <= mem[rd_addr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_w_ff <= '0;
         max_w_ff <= '1;
         mult_ff  <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_WEIGHT: min_w_ff <= csr_wdata;
            CSR_MAX_WEIGHT: max_w_ff <= csr_wdata;
            CSR_MULTIPLIER: mult_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      w_ff      <= w_in;
      b_ff      <= b_in;
      cur_ff    <= cur_in;
      ra_ff     <= ra_in;
      rb_ff     <= rb_in;
      sa_ff     <= sa_in;
      sb_ff     <= sb_in;
      ca_ff     <= ca_in;
      cb_ff     <= cb_in;
      ka_ff     <= ka_in;
      kb_ff     <= kb_in;
      keep_ff   <= keep_in;
      lose_ff   <= lose_in;
      gcred_ff  <= gcred_in;
      gknown_ff <= gknown_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   // merge rule terms
   always_comb begin
      cand     = (ra_ff != rb_ff) && (w_ff <= max_w_ff);
      both     = (sa_ff > 13'd1) && (sb_ff > 13'd1);
      need_b   = (cmd_ff == CMD_EDGE) && cand && ((sb_ff > 13'd1) || (sa_ff <= 13'd1));
      if (both) begin
         pair = (ca_ff < cb_ff) ? ca_ff : cb_ff;
      end else if (sa_ff > 13'd1) begin
         pair = ca_ff;
      end else begin
         pair = cb_ff;
      end
      if (cmd_ff != CMD_EDGE) begin
         merge = 1'b0;
      end else if (phase_ff) begin
         merge = cand && (pair > {8'd0, w_ff});
      end else begin
         merge = (ra_ff != rb_ff);
      end
      keep_sel = (sb_ff > sa_ff) ? rb_ff : ra_ff;
      lose_sel = (sb_ff > sa_ff) ? ra_ff : rb_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_in       = cmd_ff;
      w_in         = w_ff;
      b_in         = b_ff;
      cur_in       = cur_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      ka_in        = ka_ff;
      kb_in        = kb_ff;
      keep_in      = keep_ff;
      lose_in      = lose_ff;
      gcred_in     = gcred_ff;
      gknown_in    = gknown_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rd_addr      = cur_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_ent       = '{parent: clr_ff, size: 13'd1, credit: '0, known: 1'b0};
      crd_req      = '{start: 1'b0, size: sa_ff};

      // result taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + PIX_BITS'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.command;
               w_in     = req_data.edge_weight;
               b_in     = req_data.pixel_b;
               cur_in   = req_data.pixel_a;
               rd_addr  = req_data.pixel_a;
               state_in = S_WALK_A;
            end
         end
         S_WALK_A: begin
            if (rd_ent_ff.parent == cur_ff) begin
               ra_in = cur_ff;
               sa_in = rd_ent_ff.size;
               ca_in = rd_ent_ff.credit;
               ka_in = rd_ent_ff.known;
               if (cmd_ff == CMD_EDGE) begin
                  cur_in   = b_ff;
                  rd_addr  = b_ff;
                  state_in = S_WALK_B;
               end else begin
                  state_in = phase_ff ? S_CRED_A : S_DECIDE;
               end
            end else begin
               cur_in  = rd_ent_ff.parent;
               rd_addr = rd_ent_ff.parent;
            end
         end
         S_WALK_B: begin
            if (rd_ent_ff.parent == cur_ff) begin
               rb_in    = cur_ff;
               sb_in    = rd_ent_ff.size;
               cb_in    = rd_ent_ff.credit;
               kb_in    = rd_ent_ff.known;
               phase_in = phase_ff | (w_ff > min_w_ff);
               state_in = phase_in ? S_CRED_A : S_DECIDE;
            end else begin
               cur_in  = rd_ent_ff.parent;
               rd_addr = rd_ent_ff.parent;
            end
         end
         S_CRED_A: begin
            if (ka_ff) begin
               state_in = need_b ? S_CRED_B : S_DECIDE;
            end else begin
               crd_req  = '{start: 1'b1, size: sa_ff};
               state_in = S_WAIT_A;
            end
         end
         S_WAIT_A: begin
            if (crd_res.done) begin
               wr_en    = 1'b1;
               wr_addr  = ra_ff;
               wr_ent   = '{parent: ra_ff, size: sa_ff, credit: crd_res.credit, known: 1'b1};
               ca_in    = crd_res.credit;
               ka_in    = 1'b1;
               state_in = need_b ? S_CRED_B : S_DECIDE;
            end
         end
         S_CRED_B: begin
            if (kb_ff) begin
               state_in = S_DECIDE;
            end else begin
               crd_req  = '{start: 1'b1, size: sb_ff};
               state_in = S_WAIT_B;
            end
         end
         S_WAIT_B: begin
            if (crd_res.done) begin
               wr_en    = 1'b1;
               wr_addr  = rb_ff;
               wr_ent   = '{parent: rb_ff, size: sb_ff, credit: crd_res.credit, known: 1'b1};
               cb_in    = crd_res.credit;
               kb_in    = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (merge) begin
               keep_in = keep_sel;
               lose_in = lose_sel;
               pend_in.merged      = 1'b1;
               pend_in.root_label  = keep_sel;
               pend_in.region_size = sa_ff + sb_ff;
               if (phase_ff) begin
                  gcred_in  = pair - {8'd0, w_ff};
                  gknown_in = 1'b1;
                  pend_in.region_credit = pair - {8'd0, w_ff};
               end else begin
                  gcred_in  = (keep_sel == ra_ff) ? ca_ff : cb_ff;
                  gknown_in = (keep_sel == ra_ff) ? ka_ff : kb_ff;
                  pend_in.region_credit = '0;
               end
               state_in = S_LINK;
            end else begin
               pend_in.merged        = 1'b0;
               pend_in.root_label    = ra_ff;
               pend_in.region_size   = sa_ff;
               pend_in.region_credit = phase_ff ? ca_ff : '0;
               state_in = S_DONE;
            end
         end
         S_LINK: begin
            wr_en    = 1'b1;
            wr_addr  = lose_ff;
            wr_ent   = '{parent: keep_ff, size: '0, credit: '0, known: 1'b0};
            state_in = S_GROW;
         end
         S_GROW: begin
            wr_en    = 1'b1;
            wr_addr  = keep_ff;
            wr_ent   = '{parent: keep_ff, size: pend_ff.region_size,
                         credit: gcred_ff, known: gknown_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // no item taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("item accepted during store clearing");

   // the credit unit only finishes while the sequencer waits for it
   a_credit_wait: assert property (@(posedge clock) disable iff (reset)
      crd_res.done |-> ((state_ff == S_WAIT_A) || (state_ff == S_WAIT_B)))
      else $error("credit result with no waiting root");

   // a merged region holds at least two pixels
   a_merge_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.merged) |-> (rsp_data.region_size > 13'd1))
      else $error("merged region too small");

   // a new result is only raised from S_DONE, after a write-back or decision
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the done step");
`endif

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for credit_region_merge_union_find
// models the region forest and lazy credits in a scoreboard class
// depends on crmu_pkg and the block under test
`timescale 1ns / 1ps

module testbench;
   import crmu_pkg::*;

   localparam int STALL_LIMIT = 60000;
   localparam int DRAIN_CYCLES = 200;

   // region forest model and store of expected results
   class region_scoreboard;
      logic [PIX_BITS-1:0]    parent_of [PIX_COUNT];
      logic [SIZE_BITS-1:0]   size_of [PIX_COUNT];
      logic [CREDIT_BITS-1:0] credit_of_root [PIX_COUNT];
      bit                     credit_valid [PIX_COUNT];
      bit                     in_credit_phase;
      logic [15:0]            min_weight, max_weight, multiplier;
      crmu_rsp_type           pending_rsp [$];
      int                     error_count;

      function new();
         for (int i = 0; i < PIX_COUNT; i++) begin
            parent_of[i] = PIX_BITS'(i);
            size_of[i] = SIZE_BITS'(1);
            credit_of_root[i] = '0;
            credit_valid[i] = 0;
         end
         in_credit_phase = 0;
         min_weight = 16'd0;
         max_weight = 16'hFFFF;
         multiplier = 16'd256;
         error_count = 0;
      endfunction

      function void set_register(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] val);
         if (idx == CSR_MIN_WEIGHT) min_weight = val;
         else if (idx == CSR_MAX_WEIGHT) max_weight = val;
         else if (idx == CSR_MULTIPLIER) multiplier = val;
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned rem, res, bitv;
         rem = x;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      // ceil(sqrt(4 pi size) * multiplier/256), saturated
      function logic [CREDIT_BITS-1:0] start_credit(logic [SIZE_BITS-1:0] sz);
         longint unsigned r, c;
         r = int_sqrt(longint'(sz) * longint'(FOUR_PI_Q32));
         c = (r * longint'(multiplier) + ((64'd1 << 24) - 1)) >> 24;
         return (c > 64'hFFFFFF) ? 24'hFFFFFF : c[CREDIT_BITS-1:0];
      endfunction

      function logic [CREDIT_BITS-1:0] root_credit(int root);
         if (!credit_valid[root]) begin
            credit_of_root[root] = start_credit(size_of[root]);
            credit_valid[root] = 1;
         end
         return credit_of_root[root];
      endfunction

      function int find_root(int p);
         for (int s = 0; s < PIX_COUNT && parent_of[p] != p; s++) p = int'(parent_of[p]);
         return p;
      endfunction

      function int join_roots(int a, int b);
         int keep, lose;
         keep = a;
         lose = b;
         if (size_of[b] > size_of[a]) begin
            keep = b;
            lose = a;
         end
         parent_of[lose] = PIX_BITS'(keep);
         size_of[keep] = size_of[keep] + size_of[lose];
         return keep;
      endfunction

      // accepted input item: work out the result it causes
      function void note_request(crmu_req_type req);
         int ra, rb, root;
         logic [CREDIT_BITS-1:0] pair, ca, cb;
         crmu_rsp_type rsp;
         ra = find_root(int'(req.pixel_a));
         root = ra;
         rsp = '0;
         if (req.command == CMD_EDGE) begin
            rb = find_root(int'(req.pixel_b));
            if (!in_credit_phase && req.edge_weight > min_weight) in_credit_phase = 1;
            if (!in_credit_phase) begin
               if (ra != rb) begin
                  root = join_roots(ra, rb);
                  rsp.merged = 1'b1;
               end
            end else if (ra != rb && req.edge_weight <= max_weight) begin
               if (size_of[ra] > 1 && size_of[rb] > 1) begin
                  ca = root_credit(ra);
                  cb = root_credit(rb);
                  pair = (ca < cb) ? ca : cb;
               end else if (size_of[ra] > 1) begin
                  pair = root_credit(ra);
               end else begin
                  pair = root_credit(rb);
               end
               if (pair > req.edge_weight) begin
                  root = join_roots(ra, rb);
                  credit_of_root[root] = pair - {8'd0, req.edge_weight};
                  credit_valid[root] = 1;
                  rsp.merged = 1'b1;
               end
            end
         end
         rsp.root_label = PIX_BITS'(root);
         rsp.region_size = size_of[root];
         rsp.region_credit = in_credit_phase ? root_credit(root) : '0;
         pending_rsp.push_back(rsp);
      endfunction

      function void check_result(crmu_rsp_type got);
         crmu_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("result item with none expected: %h", got);
            error_count++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.merged !== want.merged) begin
            $error("merged: expected %0d actual %0d", want.merged, got.merged);
            error_count++;
         end
         if (got.root_label !== want.root_label) begin
            $error("root_label: expected %0d actual %0d", want.root_label, got.root_label);
            error_count++;
         end
         if (got.region_size !== want.region_size) begin
            $error("region_size: expected %0d actual %0d", want.region_size, got.region_size);
            error_count++;
         end
         if (got.region_credit !== want.region_credit) begin
            $error("region_credit: expected %0d actual %0d",
                   want.region_credit, got.region_credit);
            error_count++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   crmu_req_type req_data;
   crmu_rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0] csr_wdata;

   region_scoreboard sb;
   int send_idle, recv_idle;
   int quiet_cycles;

   credit_region_merge_union_find DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver ready at falling edge
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   // result check at rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("credit_region_merge_union_find test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(crmu_req_type item);
      bit done;
      @(negedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data <= item;
      done = 0;
      while (!done) begin
         @(posedge clock);
         if (req_ready) done = 1;
      end
      sb.note_request(item);
   endtask

   task automatic edge_item(int a, int b, int w);
      crmu_req_type it;
      it.command = CMD_EDGE;
      it.pixel_a = PIX_BITS'(a);
      it.pixel_b = PIX_BITS'(b);
      it.edge_weight = WEIGHT_BITS'(w);
      send_item(it);
   endtask

   task automatic query_item(int a, int b, int w);
      crmu_req_type it;
      it.command = CMD_QUERY;
      it.pixel_a = PIX_BITS'(a);
      it.pixel_b = PIX_BITS'(b);
      it.edge_weight = WEIGHT_BITS'(w);
      send_item(it);
   endtask

   // random item, mostly edges among pixels 0 to 255 with light weights
   task automatic random_item();
      crmu_req_type it;
      int span;
      span = ($urandom_range(9) == 0) ? 4095 : 255;
      it.command = ($urandom_range(99) < 15) ? CMD_QUERY : CMD_EDGE;
      it.pixel_a = PIX_BITS'($urandom_range(span));
      it.pixel_b = PIX_BITS'($urandom_range(span));
      it.edge_weight = WEIGHT_BITS'(($urandom_range(9) == 0) ?
                                    $urandom_range(65535) : $urandom_range(40));
      send_item(it);
   endtask

   // lower valid, then wait until every expected result has come
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_register(idx, val);
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet_cycles = 0;
      send_idle = 28;
      recv_idle = 58;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write(CSR_MIN_WEIGHT, 16'd100);
      csr_write(CSR_MAX_WEIGHT, 16'hFFFF);
      csr_write(CSR_MULTIPLIER, 16'd256);
      csr_done();

      // directed: unconditional merges, same region, queries, credit phase start
      edge_item(1, 2, 5);
      edge_item(2, 1, 5);
      edge_item(3, 4, 0);
      edge_item(1, 3, 100);
      query_item(4, 4095, 65535);
      query_item(4095, 0, 0);
      edge_item(4095, 0, 100);
      query_item(0, 0, 0);
      edge_item(10, 11, 101);
      edge_item(20, 21, 2);
      edge_item(1, 20, 1);
      query_item(1, 0, 0);
      edge_item(30, 31, 3);
      edge_item(30, 31, 0);
      edge_item(40, 2, 65535);
      edge_item(4095, 4094, 65535);
      edge_item(4094, 4095, 0);
      query_item(4094, 4095, 65535);
      for (int i = 0; i < 120; i++) random_item();
      drain();

      send_idle = 58;
      recv_idle = 28;
      csr_write(CSR_MULTIPLIER, 16'hFFFF);
      csr_write(CSR_MAX_WEIGHT, 16'd40);
      csr_done();
      for (int i = 0; i < 130; i++) random_item();
      drain();

      send_idle = 0;
      recv_idle = 0;
      csr_write(CSR_MULTIPLIER, 16'd0);
      csr_write(CSR_MIN_WEIGHT, 16'd0);
      csr_write(CSR_MAX_WEIGHT, 16'd0);
      csr_done();
      for (int i = 0; i < 70; i++) random_item();
      drain();

      csr_write(CSR_MULTIPLIER, 16'd1024);
      csr_write(CSR_MIN_WEIGHT, 16'hFFFF);
      csr_write(CSR_MAX_WEIGHT, 16'hFFFF);
      csr_done();
      for (int i = 0; i < 70; i++) random_item();
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.error_count == 0 && sb.pending_rsp.size() == 0) begin
         $display("credit_region_merge_union_find test passed");
      end else begin
         $display("credit_region_merge_union_find test failed");
      end
      $finish;
   end
endmodule
